### hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg: shared types and constants of the humidity/temperature frame decoder
// Holds the CRC-8 polynomial, the conversion constants and the result struct.
// ----------------------------------------------------------------------------
package htfd_pkg;

  // crc-8, x^8+x^5+x^4+1, low eight bits of the polynomial
  localparam logic [7:0]  CRC_POLY      = 8'h31;
  localparam logic [7:0]  CRC_INIT      = 8'h00;

  // the two status bits at the bottom of the raw word
  localparam logic [15:0] STATUS_MASK   = 16'hfffc;

  // measurement kind on the cmd bit
  localparam logic        KIND_TEMP     = 1'b0;
  localparam logic        KIND_HUMID    = 1'b1;

  // gains and offsets in hundredths, offsets scaled by 2^16
  localparam logic [14:0] T_GAIN        = 15'd17572;
  localparam logic [14:0] H_GAIN        = 15'd12500;
  localparam logic signed [31:0] T_OFFSET_SCALED = 32'sd307036160;  // 4685 * 65536
  localparam logic signed [31:0] H_OFFSET_SCALED = 32'sd39321600;   // 600 * 65536

  // legal span of the converted value
  localparam logic signed [14:0] VALUE_MIN = -15'sd4685;
  localparam logic signed [14:0] VALUE_MAX = 15'sd12885;

  // one decoded result word
  typedef struct packed {
    logic signed [14:0] value_hundredths;
    logic               crc_error;
    logic [15:0]        raw_word;
    logic [7:0]         received_crc;
  } result_t;

  // crc update over one byte, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/htfd_convert.sv
// ----------------------------------------------------------------------------
// htfd_convert: checksum check and fixed-point conversion of one frame
// Pure combinational: crc over both data bytes, one constant multiply,
// offset subtract and divide by 2^16 rounded toward zero.
// ----------------------------------------------------------------------------
module htfd_convert (
  input  logic               cmd,
  input  logic [7:0]         msb_byte,
  input  logic [7:0]         lsb_byte,
  input  logic [7:0]         crc_byte,
  output htfd_pkg::result_t  result
);

  logic [15:0]        raw;
  logic [15:0]        raw_masked;
  logic [7:0]         crc_calc;
  logic [14:0]        gain;
  logic signed [31:0] offset;
  logic [30:0]        product;
  logic signed [31:0] num;
  logic signed [15:0] floor_q;
  logic signed [15:0] trunc_q;

  assign raw        = {msb_byte, lsb_byte};
  assign raw_masked = raw & htfd_pkg::STATUS_MASK;

  // checksum over msb then lsb
  assign crc_calc = htfd_pkg::crc8_byte(htfd_pkg::crc8_byte(htfd_pkg::CRC_INIT, msb_byte),
                                        lsb_byte);

  // gain and offset for the selected kind
  always_comb begin
    if (cmd == htfd_pkg::KIND_HUMID) begin
      gain   = htfd_pkg::H_GAIN;
      offset = htfd_pkg::H_OFFSET_SCALED;
    end else begin
      gain   = htfd_pkg::T_GAIN;
      offset = htfd_pkg::T_OFFSET_SCALED;
    end
  end

  // scaled numerator, fits 32 bits signed
  assign product = 31'(gain) * 31'(raw_masked);
  assign num     = $signed({1'b0, product}) - offset;

  // divide by 2^16, rounding toward zero for negative values
  assign floor_q = num[31:16];
  assign trunc_q = (num[31] && (num[15:0] != 16'd0)) ? floor_q + 16'sd1 : floor_q;

  assign result.value_hundredths = trunc_q[14:0];
  assign result.crc_error        = (crc_calc != crc_byte);
  assign result.raw_word         = raw;
  assign result.received_crc     = crc_byte;

endmodule

### hdl/humidity_temp_frame_decode.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decode: sensor frame checker and converter
// Takes msb, lsb and crc bytes of one frame, checks crc-8 and gives the
// reading in hundredths of a degree C or of a percent RH.
// ----------------------------------------------------------------------------
// an accepted word goes into the input register and then into the result register
// throughput: one word per cycle while busy is low; an input register and a result register
//   hold the crc and multiply path between them
// out_valid strobes for one cycle per word; the receiver cannot stall
// reset: synchronous, clears the valid flags; busy is the registered inverse of rst_n: it is set
//   by the edge that samples reset and cleared by the edge that first samples rst_n high
module humidity_temp_frame_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_cmd,
  input  logic [7:0]         in_msb_byte,
  input  logic [7:0]         in_lsb_byte,
  input  logic [7:0]         in_crc_byte,
  output logic               out_valid,
  output logic signed [14:0] out_value_hundredths,
  output logic               out_crc_error,
  output logic [15:0]        out_raw_word,
  output logic [7:0]         out_received_crc
);

  logic              busy_r;
  logic              in_vld_r;
  logic              in_cmd_r;
  logic [7:0]        in_msb_r;
  logic [7:0]        in_lsb_r;
  logic [7:0]        in_crc_r;
  logic              out_vld_r;
  htfd_pkg::result_t res_nxt;
  htfd_pkg::result_t res_r;
  logic              accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // busy follows reset, delayed through a register
  always_ff @(posedge clk) begin
    busy_r <= !rst_n;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_r <= in_cmd;
      in_msb_r <= in_msb_byte;
      in_lsb_r <= in_lsb_byte;
      in_crc_r <= in_crc_byte;
    end
  end

  // checksum and conversion
  htfd_convert u_convert (
    .cmd      (in_cmd_r),
    .msb_byte (in_msb_r),
    .lsb_byte (in_lsb_r),
    .crc_byte (in_crc_r),
    .result   (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_value_hundredths = res_r.value_hundredths;
  assign out_crc_error        = res_r.crc_error;
  assign out_raw_word         = res_r.raw_word;
  assign out_received_crc     = res_r.received_crc;

  // every result word comes from an accepted input word, carried through both registers
  a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result word without an accepted input word");

  // raw word and crc byte travel unchanged through both registers
  a_raw_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_raw_word == {$past(in_msb_byte, 2), $past(in_lsb_byte, 2)}) &&
                  (out_received_crc == $past(in_crc_byte, 2)))
    else $error("raw word or crc byte altered");

  // converted value stays within the span of both conversions
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value_hundredths >= htfd_pkg::VALUE_MIN) &&
                  (out_value_hundredths <= htfd_pkg::VALUE_MAX))
    else $error("converted value out of range");

  // once reset has been seen released, busy stays low and every start is taken
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside of reset");

endmodule
